### rtl/aba_pkg.sv
// ----------------------------------------------------------------------------
// aba_pkg
// Shared widths, codes and controller/datapath interface types for the
// accelerometer block averager.
// ----------------------------------------------------------------------------
package aba_pkg;

  localparam int SUM_W      = 20;
  localparam int CNT_W      = 7;
  localparam int SMP_W      = 14;
  localparam int BYTE_W     = 8;
  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;
  localparam int BIDX_W     = 3;
  localparam int CODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CODE = 2'd1;

  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

  localparam logic [BIDX_W-1:0] LAST_BYTE_WIDE   = 3'd5;
  localparam logic [BIDX_W-1:0] LAST_BYTE_NARROW = 3'd2;

  localparam logic signed [SUM_W-1:0] WIDE_MAX   = SUM_W'(8191);
  localparam logic signed [SUM_W-1:0] WIDE_MIN   = -SUM_W'(8192);
  localparam logic signed [SUM_W-1:0] NARROW_MAX = SUM_W'(127);
  localparam logic signed [SUM_W-1:0] NARROW_MIN = -SUM_W'(128);

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_DIV_START = 4'b0010,
    ST_DIV_WAIT  = 4'b0100,
    ST_EMIT      = 4'b1000
  } state_t;

  typedef struct packed {
    logic              accum;
    logic              clear;
    logic              div_start;
    logic              avg_load;
    logic [AXIS_W-1:0] axis;
    logic [BIDX_W-1:0] byte_idx;
  } cmd_t;

  typedef struct packed {
    logic blk_full;
    logic div_done;
    logic wide;
  } sts_t;

endpackage

### rtl/aba_div.sv
// ----------------------------------------------------------------------------
// aba_div
// Restoring divider, one quotient bit per cycle. Signed dividend, unsigned
// nonzero divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module aba_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [aba_pkg::SUM_W-1:0]  dividend,
  input  logic        [aba_pkg::CNT_W-1:0]  divisor,
  output logic signed [aba_pkg::SUM_W-1:0]  quotient,
  output logic                              done
);

  localparam int STEP_W = $clog2(aba_pkg::SUM_W);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           step_r;
  logic                        neg_r;
  logic [aba_pkg::CNT_W-1:0]   rem_r;
  logic [aba_pkg::CNT_W-1:0]   dvs_r;
  logic [aba_pkg::SUM_W-1:0]   dq_r;

  logic [aba_pkg::SUM_W-1:0]   mag;
  logic [aba_pkg::CNT_W:0]     shifted;
  logic [aba_pkg::CNT_W:0]     diff;
  logic                        ge;
  logic [aba_pkg::CNT_W-1:0]   rem_nxt;

  always_comb begin
    mag     = dividend[aba_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
    shifted = {rem_r, dq_r[aba_pkg::SUM_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[aba_pkg::CNT_W-1:0] : shifted[aba_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(aba_pkg::SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[aba_pkg::SUM_W-1];
      dq_r  <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[aba_pkg::SUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = neg_r ? $signed(~dq_r + 1'b1) : $signed(dq_r);
  assign done     = done_r;

endmodule

### rtl/aba_dp.sv
// ----------------------------------------------------------------------------
// aba_dp
// Datapath: configuration registers, sample decode, per-axis accumulators,
// sample counter, shared divider, saturated averages and output byte select.
// ----------------------------------------------------------------------------
module aba_dp #(
  parameter int COUNT_UNIT = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [aba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [aba_pkg::BYTE_W-1:0]         in_x_high,
  input  logic [aba_pkg::BYTE_W-1:0]         in_x_low,
  input  logic [aba_pkg::BYTE_W-1:0]         in_y_high,
  input  logic [aba_pkg::BYTE_W-1:0]         in_y_low,
  input  logic [aba_pkg::BYTE_W-1:0]         in_z_high,
  input  logic [aba_pkg::BYTE_W-1:0]         in_z_low,
  input  aba_pkg::cmd_t                      cmd,
  output aba_pkg::sts_t                      sts,
  output logic [aba_pkg::BYTE_W-1:0]         out_byte
);

  logic                               wide_r;
  logic [aba_pkg::CODE_W-1:0]         code_r;
  logic signed [aba_pkg::SUM_W-1:0]   sum_r [aba_pkg::AXES];
  logic [aba_pkg::CNT_W-1:0]          count_r;
  logic [aba_pkg::SMP_W-1:0]          avg_r [aba_pkg::AXES];

  logic [aba_pkg::BYTE_W-1:0]         hi [aba_pkg::AXES];
  logic [aba_pkg::BYTE_W-1:0]         lo [aba_pkg::AXES];
  logic signed [aba_pkg::SUM_W-1:0]   val [aba_pkg::AXES];
  logic [aba_pkg::CNT_W-1:0]          count_nxt;
  logic [aba_pkg::CNT_W-1:0]          target;
  logic                               cfg_hit;

  logic signed [aba_pkg::SUM_W-1:0]   quot;
  logic                               div_done;
  logic signed [aba_pkg::SUM_W-1:0]   sat;

  logic [aba_pkg::AXIS_W-1:0]         out_axis;
  logic [aba_pkg::SMP_W-1:0]          out_avg;

  assign hi[0] = in_x_high;
  assign hi[1] = in_y_high;
  assign hi[2] = in_z_high;
  assign lo[0] = in_x_low;
  assign lo[1] = in_y_low;
  assign lo[2] = in_z_low;

  always_comb begin
    for (int a = 0; a < aba_pkg::AXES; a++) begin
      val[a] = wide_r ? aba_pkg::SUM_W'($signed({hi[a], lo[a][7:2]}))
                      : aba_pkg::SUM_W'($signed(hi[a]));
    end
  end

  assign count_nxt = count_r + 1'b1;
  assign target    = aba_pkg::CNT_W'((int'(code_r) + 1) * COUNT_UNIT);
  assign cfg_hit   = cfg_wr_en && ((cfg_index == aba_pkg::CFG_WIDE_MODE) ||
                                   (cfg_index == aba_pkg::CFG_COUNT_CODE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r  <= 1'b1;
      code_r  <= '0;
      count_r <= '0;
      for (int a = 0; a < aba_pkg::AXES; a++) sum_r[a] <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == aba_pkg::CFG_WIDE_MODE) wide_r <= cfg_wdata[0];
      else code_r <= cfg_wdata;
      count_r <= '0;
      for (int a = 0; a < aba_pkg::AXES; a++) sum_r[a] <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
      for (int a = 0; a < aba_pkg::AXES; a++) sum_r[a] <= '0;
    end else if (cmd.accum) begin
      count_r <= count_nxt;
      for (int a = 0; a < aba_pkg::AXES; a++) sum_r[a] <= sum_r[a] + val[a];
    end
  end

  aba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r[cmd.axis]),
    .divisor  (count_r),
    .quotient (quot),
    .done     (div_done)
  );

  always_comb begin
    if (wide_r) begin
      if (quot > aba_pkg::WIDE_MAX) sat = aba_pkg::WIDE_MAX;
      else if (quot < aba_pkg::WIDE_MIN) sat = aba_pkg::WIDE_MIN;
      else sat = quot;
    end else begin
      if (quot > aba_pkg::NARROW_MAX) sat = aba_pkg::NARROW_MAX;
      else if (quot < aba_pkg::NARROW_MIN) sat = aba_pkg::NARROW_MIN;
      else sat = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_load) avg_r[cmd.axis] <= sat[aba_pkg::SMP_W-1:0];
  end

  always_comb begin
    out_axis = wide_r ? cmd.byte_idx[2:1] : cmd.byte_idx[1:0];
    out_avg  = avg_r[out_axis];
    if (!wide_r) out_byte = out_avg[7:0];
    else if (cmd.byte_idx[0]) out_byte = {out_avg[5:0], 2'b00};
    else out_byte = out_avg[13:6];
  end

  assign sts.blk_full = (count_nxt >= target);
  assign sts.div_done = div_done;
  assign sts.wide     = wide_r;

endmodule

### rtl/aba_ctrl.sv
// ----------------------------------------------------------------------------
// aba_ctrl
// Controller: sample intake, per-axis divide sequencing and result burst.
// ----------------------------------------------------------------------------
module aba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_last,
  input  aba_pkg::sts_t sts,
  output aba_pkg::cmd_t cmd
);

  aba_pkg::state_t                 state_r, state_nxt;
  logic [aba_pkg::AXIS_W-1:0]      axis_r, axis_nxt;
  logic [aba_pkg::BIDX_W-1:0]      bidx_r, bidx_nxt;
  logic                            last;

  assign last = (bidx_r == (sts.wide ? aba_pkg::LAST_BYTE_WIDE
                                     : aba_pkg::LAST_BYTE_NARROW));

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    bidx_nxt      = bidx_r;
    cmd           = '0;
    cmd.axis      = axis_r;
    cmd.byte_idx  = bidx_r;
    unique case (state_r)
      aba_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (sts.blk_full) begin
            state_nxt = aba_pkg::ST_DIV_START;
            axis_nxt  = aba_pkg::AXIS_X;
          end
        end
      end
      aba_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = aba_pkg::ST_DIV_WAIT;
      end
      aba_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          if (axis_r == aba_pkg::AXIS_LAST) begin
            cmd.clear = 1'b1;
            bidx_nxt  = '0;
            state_nxt = aba_pkg::ST_EMIT;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = aba_pkg::ST_DIV_START;
          end
        end
      end
      aba_pkg::ST_EMIT: begin
        if (out_ready) begin
          if (last) state_nxt = aba_pkg::ST_IDLE;
          else bidx_nxt = bidx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = aba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aba_pkg::ST_IDLE;
      axis_r  <= '0;
      bidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      bidx_r  <= bidx_nxt;
    end
  end

  assign in_ready  = (state_r == aba_pkg::ST_IDLE);
  assign out_valid = (state_r == aba_pkg::ST_EMIT);
  assign out_last  = last;

endmodule

### rtl/accel_block_average.sv
// ----------------------------------------------------------------------------
// accel_block_average
// Boxcar average decimator for three-axis accelerometer samples.
//
// Input channel (in_*): one request per sample, six raw register bytes.
// Output channel (out_*): one request per averaged byte, X then Y then Z,
// high before low; out_last marks the final byte of a burst (six bytes in
// wide mode, three in narrow mode).
// Configuration (cfg_*): index 0 selects wide mode, index 1 the count code;
// any such write clears the sums and the sample count. Write only when idle.
// A sample that does not complete a block is taken and the block stays idle.
// The completing sample starts three serial divides on one shared radix-2
// divider, one axis at a time, then the burst is presented one
// byte per cycle while out_ready is high. No sample is taken from the
// completing sample until the last byte of the burst is accepted.
// A stalled receiver holds the current byte and last flag steady.
// Reset: wide mode on, count code 0, sums and count cleared, no burst pending.
// ----------------------------------------------------------------------------
module accel_block_average #(
  parameter int COUNT_UNIT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [aba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [aba_pkg::BYTE_W-1:0]     in_x_high,
  input  logic [aba_pkg::BYTE_W-1:0]     in_x_low,
  input  logic [aba_pkg::BYTE_W-1:0]     in_y_high,
  input  logic [aba_pkg::BYTE_W-1:0]     in_y_low,
  input  logic [aba_pkg::BYTE_W-1:0]     in_z_high,
  input  logic [aba_pkg::BYTE_W-1:0]     in_z_low,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [aba_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_last
);

  aba_pkg::cmd_t cmd;
  aba_pkg::sts_t sts;

  aba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .sts       (sts),
    .cmd       (cmd)
  );

  aba_dp #(
    .COUNT_UNIT (COUNT_UNIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_x_high (in_x_high),
    .in_x_low  (in_x_low),
    .in_y_high (in_y_high),
    .in_y_low  (in_y_low),
    .in_z_high (in_z_high),
    .in_z_low  (in_z_low),
    .cmd       (cmd),
    .sts       (sts),
    .out_byte  (out_byte)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for accel_block_average. A directed table followed by
// random sample streams under several mode and count settings; every output
// byte is held to a typed burst or a boxcar average of the accepted samples.
// ----------------------------------------------------------------------------
module tb;

  localparam int UNIT        = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 10;
  localparam int DRAIN       = 100;
  localparam int PHASES      = 8;

  localparam logic [aba_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [aba_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // index 0 x_high, 1 x_low, 2 y_high, 3 y_low, 4 z_high, 5 z_low
  typedef logic [5:0][aba_pkg::BYTE_W-1:0] sample_t;

  typedef struct packed {
    logic [aba_pkg::BYTE_W-1:0] data;
    logic                       last;
  } avg_byte_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [aba_pkg::CFG_IDX_W-1:0]  idx;
    logic [aba_pkg::CFG_DATA_W-1:0] wdata;
    sample_t                        smp;
    logic                           typed;
    sample_t                        burst;
  } row_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [aba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [aba_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic [aba_pkg::BYTE_W-1:0]     in_x_high = '0;
  logic [aba_pkg::BYTE_W-1:0]     in_x_low  = '0;
  logic [aba_pkg::BYTE_W-1:0]     in_y_high = '0;
  logic [aba_pkg::BYTE_W-1:0]     in_y_low  = '0;
  logic [aba_pkg::BYTE_W-1:0]     in_z_high = '0;
  logic [aba_pkg::BYTE_W-1:0]     in_z_low  = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [aba_pkg::BYTE_W-1:0]     out_byte;
  logic                           out_last;

  logic                             mode_wide;
  logic [aba_pkg::CODE_W-1:0]       code;
  logic signed [aba_pkg::SUM_W-1:0] acc [aba_pkg::AXES];
  logic [aba_pkg::CNT_W-1:0]        taken;
  avg_byte_t                        avg_due [$];

  int errors        = 0;
  int samples_sent  = 0;
  int bytes_checked = 0;
  int writes_done   = 0;
  int cycle_count   = 0;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  accel_block_average #(.COUNT_UNIT(UNIT)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_x_high(in_x_high),
    .in_x_low (in_x_low),
    .in_y_high(in_y_high),
    .in_y_low (in_y_low),
    .in_z_high(in_z_high),
    .in_z_low (in_z_low),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin : check_output
    avg_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (avg_due.size() == 0) begin
        report_mismatch($sformatf("byte %02h with none expected", out_byte));
      end else begin
        want = avg_due.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("byte %02h, expected %02h", out_byte, want.data));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
      end
    end
  end

  function automatic void clear_sums();
    for (int a = 0; a < aba_pkg::AXES; a++) acc[a] = '0;
    taken = '0;
  endfunction

  function automatic int average_step(sample_t s,
                                      output logic [aba_pkg::BYTE_W-1:0] res [6]);
    logic signed [aba_pkg::SMP_W-1:0]  w;
    logic signed [aba_pkg::BYTE_W-1:0] nb;
    logic [aba_pkg::SMP_W-1:0]         t;
    int n;
    int v;
    int avg;
    int target;
    n = 0;
    target = (int'(code) + 1) * UNIT;
    for (int a = 0; a < aba_pkg::AXES; a++) begin
      w = {s[2*a], s[2*a+1][7:2]};
      nb = s[2*a];
      v = mode_wide ? int'(w) : int'(nb);
      acc[a] = acc[a] + aba_pkg::SUM_W'(v);
    end
    taken = taken + 1'b1;
    if (int'(taken) < target) return 0;
    for (int a = 0; a < aba_pkg::AXES; a++) begin
      avg = int'(acc[a]) / int'(taken);
      if (mode_wide) begin
        if (avg > int'(aba_pkg::WIDE_MAX)) avg = int'(aba_pkg::WIDE_MAX);
        if (avg < int'(aba_pkg::WIDE_MIN)) avg = int'(aba_pkg::WIDE_MIN);
        t = avg[aba_pkg::SMP_W-1:0];
        res[n] = t[13:6];
        res[n+1] = {t[5:0], 2'b00};
        n = n + 2;
      end else begin
        if (avg > int'(aba_pkg::NARROW_MAX)) avg = int'(aba_pkg::NARROW_MAX);
        if (avg < int'(aba_pkg::NARROW_MIN)) avg = int'(aba_pkg::NARROW_MIN);
        res[n] = avg[aba_pkg::BYTE_W-1:0];
        n = n + 1;
      end
    end
    clear_sums();
    return n;
  endfunction

  function automatic sample_t mk_sample(logic [7:0] xh, logic [7:0] xl, logic [7:0] yh,
                                        logic [7:0] yl, logic [7:0] zh, logic [7:0] zl);
    sample_t s;
    s[0] = xh;
    s[1] = xl;
    s[2] = yh;
    s[3] = yl;
    s[4] = zh;
    s[5] = zl;
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    for (int a = 0; a < aba_pkg::AXES; a++) begin
      case ($urandom_range(0, 3))
        0: s[2*a] = 8'($urandom);
        1: s[2*a] = 8'h7F;
        2: s[2*a] = 8'h80;
        default: s[2*a] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      endcase
      s[2*a+1] = 8'($urandom);
    end
    return s;
  endfunction

  function automatic row_t sample_row(sample_t s, logic typed, sample_t burst);
    row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.smp = s;
    r.typed = typed;
    r.burst = burst;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [aba_pkg::CFG_IDX_W-1:0] idx,
                                   logic [aba_pkg::CFG_DATA_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.wdata = val;
    return r;
  endfunction

  task automatic send_sample(sample_t s, logic typed, sample_t burst);
    logic [aba_pkg::BYTE_W-1:0] res [6];
    int n;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < in_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_x_high <= s[0];
    in_x_low  <= s[1];
    in_y_high <= s[2];
    in_y_low  <= s[3];
    in_z_high <= s[4];
    in_z_low  <= s[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    n = average_step(s, res);
    for (int k = 0; k < n; k++)
      avg_due.push_back('{typed ? burst[k] : res[k], k == n - 1});
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (avg_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [aba_pkg::CFG_IDX_W-1:0] idx,
                           logic [aba_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    writes_done++;
    case (idx)
      aba_pkg::CFG_WIDE_MODE: begin
        mode_wide = val[0];
        clear_sums();
      end
      aba_pkg::CFG_COUNT_CODE: begin
        code = val;
        clear_sums();
      end
      default: ;
    endcase
  endtask

  initial begin
    row_t                       plan [$];
    sample_t                    top_burst;
    sample_t                    bottom_burst;
    int                         items;
    logic                       wide_pick;
    logic [aba_pkg::CODE_W-1:0] code_pick;

    mode_wide = 1'b1;
    code = '0;
    clear_sums();

    top_burst    = mk_sample(8'h7F, 8'hFC, 8'h7F, 8'hFC, 8'h7F, 8'hFC);
    bottom_burst = mk_sample(8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00);
    for (int i = 0; i < 8; i++)
      plan.push_back(sample_row(mk_sample(8'h7F, 8'hFF, 8'h7F, 8'hFC, 8'h7F, 8'hFD),
                                i == 7, top_burst));
    plan.push_back(sample_row(mk_sample(8'h12, 8'h34, 8'hF0, 8'h0C, 8'h00, 8'h80),
                              1'b0, '0));
    plan.push_back(cfg_row(aba_pkg::CFG_WIDE_MODE, 3'd1));
    plan.push_back(cfg_row(CFG_SPARE_B, 3'd7));
    for (int i = 0; i < 8; i++)
      plan.push_back(sample_row(mk_sample(8'h80, 8'h03, 8'h80, 8'h00, 8'h80, 8'h02),
                                i == 7, bottom_burst));
    plan.push_back(cfg_row(aba_pkg::CFG_WIDE_MODE, 3'b110));
    for (int i = 0; i < 8; i++)
      plan.push_back(sample_row(mk_sample(8'h7F, 8'($urandom), 8'h80, 8'($urandom),
                                          (i % 2) ? 8'h80 : 8'h7F, 8'($urandom)),
                                1'b0, '0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        go_idle();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_sample(plan[i].smp, plan[i].typed, plan[i].burst);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      go_idle();
      wide_pick = (p < 4) ? (p % 2 == 0) : 1'($urandom_range(0, 1));
      if (p < 2)
        code_pick = '0;
      else if (p < 4)
        code_pick = '1;
      else
        code_pick = aba_pkg::CODE_W'($urandom_range(0, 7));
      if ($urandom_range(0, 1)) begin
        write_reg(aba_pkg::CFG_WIDE_MODE, {2'($urandom_range(0, 3)), wide_pick});
        write_reg(aba_pkg::CFG_COUNT_CODE, code_pick);
      end else begin
        write_reg(aba_pkg::CFG_COUNT_CODE, code_pick);
        write_reg(aba_pkg::CFG_WIDE_MODE, {2'($urandom_range(0, 3)), wide_pick});
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  aba_pkg::CFG_DATA_W'($urandom_range(0, 7)));
      case (p % 4)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 70;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 70;
        end
        default: begin
          in_idle_pct = 26;
          out_stall_pct = 26;
        end
      endcase
      items = 64 + $urandom_range(0, 6);
      for (int k = 0; k < items; k++) begin
        if (k == items / 2 && p % 2 == 1) go_idle();
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (avg_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d samples in both modes at count codes 0, 7 and random picks",
             samples_sent);
    $display("checked %0d averaged bytes after %0d register writes",
             bytes_checked, writes_done);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### accel_block_average.f
rtl/aba_pkg.sv
rtl/aba_div.sv
rtl/aba_dp.sv
rtl/aba_ctrl.sv
rtl/accel_block_average.sv
bench/tb.sv
